[src/tpg_pkg.sv]
`default_nettype none
package tpg_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_TACC,
        ST_DACC,
        ST_TCR_START,
        ST_DIV_TCR,
        ST_PHASE,
        ST_MUL_H,
        ST_MUL_V1,
        ST_MUL_V2,
        ST_FINISH,
        ST_OUT
    } tpg_state_t;

    localparam logic [2:0] REG_START  = 3'd0;
    localparam logic [2:0] REG_TARGET = 3'd1;
    localparam logic [2:0] REG_SPEED  = 3'd2;
    localparam logic [2:0] REG_ACCEL  = 3'd3;
    localparam logic [2:0] REG_TSTEP  = 3'd4;
    localparam logic [2:0] REG_TRI    = 3'd5;

    localparam logic [31:0] TMAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } tpg_div_req_t;

endpackage
`default_nettype wire

[src/trapezoidal_profile_generator.sv]
`default_nettype none
// Each transaction on the input channel produces one setpoint transaction.
// After the input transaction, a bit-serial division gives the acceleration
// time, a second division for the cruise time runs only when tri mode is off
// and distance remains after both ramps, and
// up to five passes through one shared 32 by 32 multiplier, one product per
// cycle, build the offset for the current phase. The input is not ready while
// a tick is in progress or while its result waits to be taken.
module trapezoidal_profile_generator
    import tpg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_restart,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_setpoint,
    output logic             m_move_done
);

    logic signed [31:0] start_reg, target_reg;
    logic [30:0] speed_reg, accel_reg;
    logic [15:0] tstep_reg;
    logic        tri_reg;
    logic [31:0] elapsed_reg, elapsed_next;
    logic        done_reg, done_next;

    tpg_state_t  state_reg, state_next;
    logic [31:0] tacc_reg, tacc_next;
    logic [31:0] tcr_reg, tcr_next;
    logic [32:0] dacc_reg, dacc_next;
    logic [32:0] adist_reg, adist_next;
    logic        up_reg, up_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] tau_reg, tau_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  hstep_reg, hstep_next;
    logic [63:0] sq_reg, sq_next;
    logic signed [49:0] off_reg, off_next;
    logic [31:0] sp_reg, sp_next;
    logic        mdone_reg, mdone_next;
    logic        mvalid_reg, mvalid_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    tpg_div_req_t div_req;
    logic        div_busy;
    logic [31:0] div_q;

    logic        wr_en;
    logic [2:0]  wr_idx;
    logic signed [32:0] distance;
    logic [31:0] t2, ttot;
    logic [32:0] s2, s3;
    logic [33:0] rem;
    logic signed [51:0] pos;

    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[4:2];
    assign pready = 1'b1;

    always_comb begin
        case (wr_idx)
            REG_START:  prdata = start_reg;
            REG_TARGET: prdata = target_reg;
            REG_SPEED:  prdata = {1'b0, speed_reg};
            REG_ACCEL:  prdata = {1'b0, accel_reg};
            REG_TSTEP:  prdata = {16'd0, tstep_reg};
            REG_TRI:    prdata = {31'd0, tri_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            target_reg <= '0;
            speed_reg  <= 31'd65536;
            accel_reg  <= 31'd65536;
            tstep_reg  <= 16'd655;
            tri_reg    <= 1'b0;
        end else if (wr_en) begin
            case (wr_idx)
                REG_START:  start_reg  <= pwdata;
                REG_TARGET: target_reg <= pwdata;
                REG_SPEED:  speed_reg  <= pwdata[30:0];
                REG_ACCEL:  accel_reg  <= pwdata[30:0];
                REG_TSTEP:  tstep_reg  <= pwdata[15:0];
                REG_TRI:    tri_reg    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    tpg_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign mul_p = mul_a * mul_b;

    assign distance = 33'(target_reg) - 33'(start_reg);
    assign s2   = {1'b0, tacc_reg} + {1'b0, tcr_reg};
    assign t2   = s2[32] ? TMAX : s2[31:0];
    assign s3   = {1'b0, t2} + {1'b0, tacc_reg};
    assign ttot = s3[32] ? TMAX : s3[31:0];
    assign rem  = {1'b0, adist_reg} - {dacc_reg, 1'b0};
    assign pos  = up_reg ? 52'(start_reg) + 52'(off_reg) : 52'(start_reg) - 52'(off_reg);

    always_comb begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        done_next    = done_reg;
        tacc_next    = tacc_reg;
        tcr_next     = tcr_reg;
        dacc_next    = dacc_reg;
        adist_next   = adist_reg;
        up_next      = up_reg;
        phase_next   = phase_reg;
        tau_next     = tau_reg;
        acc_next     = acc_reg;
        hstep_next   = hstep_reg;
        sq_next      = sq_reg;
        off_next     = off_reg;
        sp_next      = sp_reg;
        mdone_next   = mdone_reg;
        mvalid_next  = mvalid_reg;
        div_req      = '0;
        mul_a        = '0;
        mul_b        = '0;
        s_ready      = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_restart) begin
                        elapsed_next = '0;
                        done_next    = 1'b0;
                    end
                    up_next      = distance > 0;
                    adist_next   = distance[32] ? 33'(-distance) : 33'(distance);
                    div_req.start    = 1'b1;
                    div_req.dividend = {17'd0, speed_reg, 16'd0};
                    div_req.divisor  = {1'b0, accel_reg};
                    tau_next     = '0;
                    state_next   = ST_DIV_TACC;
                end
            end
            ST_DIV_TACC: begin
                if (!div_busy) begin
                    tacc_next  = div_q;
                    tau_next   = div_q;
                    hstep_next = 2'd0;
                    state_next = ST_DACC;
                end
            end
            ST_DACC, ST_MUL_H: begin
                // Three passes: tau squared, then the acceleration times its low half
                // and then the acceleration times its high half.
                case (hstep_reg)
                    2'd0: begin
                        mul_a   = tau_reg;
                        mul_b   = tau_reg;
                        sq_next = mul_p;
                        hstep_next = 2'd1;
                    end
                    2'd1: begin
                        mul_a    = {1'b0, accel_reg};
                        mul_b    = sq_reg[31:0];
                        acc_next = {32'd0, mul_p[63:32]};
                        hstep_next = 2'd2;
                    end
                    default: begin
                        mul_a      = {1'b0, accel_reg};
                        mul_b      = sq_reg[63:32];
                        acc_next   = 64'((acc_reg + mul_p) >> 17);
                        hstep_next = 2'd0;
                        if (state_reg == ST_DACC) begin
                            dacc_next  = acc_next[32:0];
                            state_next = ST_TCR_START;
                        end else begin
                            if (phase_reg == 2'd0) begin
                                off_next = off_reg + 50'(acc_next[48:0]);
                            end else begin
                                off_next = off_reg - 50'(acc_next[48:0]);
                            end
                            state_next = ST_FINISH;
                        end
                    end
                endcase
            end
            ST_TCR_START: begin
                tcr_next = '0;
                if (!tri_reg && !rem[33] && rem != 34'd0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {14'd0, rem[33:0], 16'd0};
                    div_req.divisor  = {1'b0, speed_reg};
                    state_next       = ST_DIV_TCR;
                end else begin
                    state_next = ST_PHASE;
                end
            end
            ST_DIV_TCR: begin
                if (!div_busy) begin
                    tcr_next   = div_q;
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE: begin
                hstep_next = 2'd0;
                if (elapsed_reg <= tacc_reg) begin
                    phase_next = 2'd0;
                    off_next   = '0;
                    tau_next   = elapsed_reg;
                    state_next = ST_MUL_H;
                end else if (elapsed_reg <= t2) begin
                    phase_next = 2'd1;
                    off_next   = 50'(dacc_reg);
                    tau_next   = elapsed_reg - tacc_reg;
                    state_next = ST_MUL_V1;
                end else if (elapsed_reg < ttot) begin
                    phase_next = 2'd2;
                    off_next   = 50'(dacc_reg);
                    tau_next   = t2 - tacc_reg;
                    state_next = ST_MUL_V1;
                end else begin
                    phase_next = 2'd3;
                    done_next  = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_V1: begin
                mul_a    = {1'b0, speed_reg};
                mul_b    = tau_reg;
                off_next = off_reg + 50'(mul_p[63:16]);
                if (phase_reg == 2'd2) begin
                    tau_next   = elapsed_reg - t2;
                    state_next = ST_MUL_V2;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_V2: begin
                mul_a      = {1'b0, speed_reg};
                mul_b      = tau_reg;
                off_next   = off_reg + 50'(mul_p[63:16]);
                state_next = ST_MUL_H;
            end
            ST_FINISH: begin
                if (phase_reg == 2'd3) begin
                    sp_next = target_reg;
                end else if (pos > 52'sd2147483647) begin
                    sp_next = 32'h7FFF_FFFF;
                end else if (pos < -52'sd2147483648) begin
                    sp_next = 32'h8000_0000;
                end else begin
                    sp_next = pos[31:0];
                end
                mdone_next   = done_reg;
                elapsed_next = ({1'b0, elapsed_reg} + 33'(tstep_reg) > 33'(TMAX))
                    ? TMAX : elapsed_reg + 32'(tstep_reg);
                mvalid_next  = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    mvalid_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= '0;
            done_reg    <= 1'b0;
            mvalid_reg  <= 1'b0;
            hstep_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            done_reg    <= done_next;
            mvalid_reg  <= mvalid_next;
            hstep_reg   <= hstep_next;
        end
        tacc_reg  <= tacc_next;
        tcr_reg   <= tcr_next;
        dacc_reg  <= dacc_next;
        adist_reg <= adist_next;
        up_reg    <= up_next;
        phase_reg <= phase_next;
        tau_reg   <= tau_next;
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        off_reg   <= off_next;
        sp_reg    <= sp_next;
        mdone_reg <= mdone_next;
    end

    assign m_valid     = mvalid_reg;
    assign m_setpoint  = sp_reg;
    assign m_move_done = mdone_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == ST_OUT)
        else $error("result shown outside output state");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH |=> m_valid)
        else $error("finished tick without a result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> s_ready)
        else $error("not ready after result taken");

endmodule
`default_nettype wire

[src/tpg_divider.sv]
`default_nettype none
module tpg_divider
    import tpg_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire tpg_div_req_t req,
    output logic              busy,
    output logic [31:0]       quotient
);

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        ovf_reg, ovf_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        ovf_next  = ovf_reg;
        shifted   = {rem_reg[31:0], quo_reg[63]};
        trial     = shifted - {1'b0, dsr_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
            ovf_next  = 1'b0;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            if (cnt_reg > 7'd32 && quo_next[0]) begin
                ovf_next = 1'b1;
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = (ovf_reg || dsr_reg == 32'd0) ? TMAX : quo_reg[31:0];

    assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy)
        else $error("divider did not start");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> cnt_reg != 7'd0)
        else $error("divider busy with empty count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !busy && !req.start |=> !busy)
        else $error("divider became busy unprompted");

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import tpg_pkg::*;

    localparam logic [4:0] ADDR_SPARE_LO = 5'd24;
    localparam logic [4:0] ADDR_SPARE_HI = 5'd28;

    typedef struct {
        logic [31:0] setpoint;
        logic        move_done;
    } tick_result_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic        s_restart;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_setpoint;
    logic        m_move_done;

    trapezoidal_profile_generator u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_setpoint  (m_setpoint),
        .m_move_done (m_move_done)
    );

    logic signed [31:0] cfg_start;
    logic signed [31:0] cfg_target;
    logic [30:0]        cfg_speed;
    logic [30:0]        cfg_accel;
    logic [15:0]        cfg_tstep;
    logic               cfg_tri;
    logic [31:0]        elapsed;
    logic               done_flag;

    tick_result_t setpoint_queue[$];
    int unsigned  n_errors;
    int unsigned  n_ticks;
    int unsigned  n_done_seen;
    int unsigned  n_checked;
    bit           calm;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("tb failed");
        $finish;
    end

    function automatic logic [63:0] half_accel_sq(logic [30:0] a, logic [63:0] tau);
        logic [127:0] p;
        p = {97'b0, a} * {64'b0, tau} * {64'b0, tau};
        return p[112:49];
    endfunction

    function automatic logic [63:0] speed_dist(logic [30:0] v, logic [63:0] tau);
        logic [127:0] p;
        p = {97'b0, v} * {64'b0, tau};
        return p[79:16];
    endfunction

    function automatic logic [31:0] sat_time(logic [63:0] x);
        return (x > 64'h0000_0000_FFFF_FFFF) ? TMAX : x[31:0];
    endfunction

    function automatic tick_result_t predict_tick(logic restart);
        tick_result_t r;
        longint       distance;
        longint       off;
        longint       pos;
        logic [63:0]  adist;
        logic [63:0]  t;
        logic [63:0]  t_acc;
        logic [63:0]  d_acc;
        logic [63:0]  t_cr;
        logic [63:0]  t2;
        logic [63:0]  t_total;
        logic [63:0]  tau;
        logic         up;
        logic         arrived;
        distance = longint'(cfg_target) - longint'(cfg_start);
        up = distance > 0;
        adist = (distance < 0) ? -distance : distance;
        if (restart) begin
            elapsed = '0;
            done_flag = 1'b0;
        end
        t = {32'b0, elapsed};
        if (cfg_accel == 0) begin
            t_acc = {32'b0, TMAX};
        end else begin
            t_acc = {32'b0, sat_time(({33'b0, cfg_speed} << 16) / {33'b0, cfg_accel})};
        end
        d_acc = half_accel_sq(cfg_accel, t_acc);
        t_cr = '0;
        if (!cfg_tri && adist > 2 * d_acc) begin
            if (cfg_speed == 0) begin
                t_cr = {32'b0, TMAX};
            end else begin
                t_cr = {32'b0, sat_time(((adist - 2 * d_acc) << 16) / {33'b0, cfg_speed})};
            end
        end
        t2 = {32'b0, sat_time(t_acc + t_cr)};
        t_total = {32'b0, sat_time(t2 + t_acc)};
        arrived = 1'b0;
        off = 0;
        if (t <= t_acc) begin
            off = longint'(half_accel_sq(cfg_accel, t));
        end else if (t <= t2) begin
            off = longint'(d_acc + speed_dist(cfg_speed, t - t_acc));
        end else if (t < t_total) begin
            tau = t - t2;
            off = longint'(d_acc + speed_dist(cfg_speed, t2 - t_acc)
                  + speed_dist(cfg_speed, tau)) - longint'(half_accel_sq(cfg_accel, tau));
        end else begin
            done_flag = 1'b1;
            arrived = 1'b1;
        end
        if (arrived) begin
            pos = longint'(cfg_target);
        end else begin
            pos = longint'(cfg_start) + (up ? off : -off);
            if (pos > 64'sd2147483647) pos = 64'sd2147483647;
            if (pos < -64'sd2147483648) pos = -64'sd2147483648;
        end
        elapsed = sat_time({32'b0, elapsed} + {48'b0, cfg_tstep});
        r.setpoint = pos[31:0];
        r.move_done = done_flag;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            setpoint_queue.push_back(predict_tick(s_restart));
            n_ticks++;
        end
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("mismatch %0d at %0t: %s got %h expected %h", n_errors, $realtime, what,
                 got, want);
    endtask

    always @(posedge aclk) begin
        tick_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (setpoint_queue.size() == 0) begin
                report("unexpected transaction", m_setpoint, '0);
            end else begin
                want = setpoint_queue.pop_front();
                n_checked++;
                if (want.move_done) n_done_seen++;
                if (m_setpoint !== want.setpoint)
                    report("setpoint", m_setpoint, want.setpoint);
                if (m_move_done !== want.move_done)
                    report("move_done", {31'b0, m_move_done}, {31'b0, want.move_done});
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
    end

    task automatic send_tick(logic restart);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (setpoint_queue.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [4:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            {REG_START, 2'b00}:  cfg_start = data;
            {REG_TARGET, 2'b00}: cfg_target = data;
            {REG_SPEED, 2'b00}:  cfg_speed = data[30:0];
            {REG_ACCEL, 2'b00}:  cfg_accel = data[30:0];
            {REG_TSTEP, 2'b00}:  cfg_tstep = data[15:0];
            {REG_TRI, 2'b00}:    cfg_tri = data[0];
            default: ;
        endcase
    endtask

    task automatic set_move(logic [31:0] start, logic [31:0] target, logic [30:0] speed,
                            logic [30:0] accel, logic [15:0] tstep, logic tri_mode);
        wait_idle();
        write_reg({REG_START, 2'b00}, start);
        write_reg({REG_TARGET, 2'b00}, target);
        write_reg({REG_SPEED, 2'b00}, {1'b0, speed});
        write_reg({REG_ACCEL, 2'b00}, {1'b0, accel});
        write_reg({REG_TSTEP, 2'b00}, {16'b0, tstep});
        write_reg({REG_TRI, 2'b00}, {31'b0, tri_mode});
    endtask

    task automatic run_ticks(int n);
        send_tick(1'b1);
        repeat (n - 1) send_tick(1'b0);
    endtask

    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_short_moves();
        set_move(32'h0001_0000, 32'h0003_0000, 31'h0001_0000, 31'h0001_0000, 16'hFFFF, 1'b0);
        run_ticks(6);
        set_move(32'h0005_0000, 32'h0002_0000, 31'h0001_0000, 31'h0002_0000, 16'hFFFF, 1'b1);
        run_ticks(5);
        set_move(32'h0000_0000, 32'h0000_8000, 31'h0004_0000, 31'h0001_0000, 16'hFFFF, 1'b0);
        run_ticks(5);
        set_move(32'h1234_0000, 32'h1234_0000, 31'h0001_0000, 31'h0001_0000, 16'h8000, 1'b0);
        run_ticks(2);
    endtask

    task automatic test_extremes();
        set_move(32'h7FFF_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 1'b0);
        run_ticks(3);
        set_move(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h0000_0001, 16'hFFFF, 1'b0);
        run_ticks(2);
        set_move(32'h0000_0000, 32'h0010_0000, 31'h0001_0000, 31'h0000_0000, 16'h0001, 1'b0);
        run_ticks(2);
        set_move(32'h0000_0000, 32'h0010_0000, 31'h0000_0000, 31'h0001_0000, 16'hFFFF, 1'b0);
        run_ticks(2);
        wait_idle();
        write_reg(ADDR_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(ADDR_SPARE_HI, 32'hFFFF_FFFF);
        send_tick(1'b0);
    endtask

    task automatic test_sticky_done();
        set_move(32'h0000_0000, 32'h0001_0000, 31'h0001_0000, 31'h0001_0000, 16'hFFFF, 1'b1);
        run_ticks(4);
        set_move(32'h0000_0000, 32'h0100_0000, 31'h0001_0000, 31'h0001_0000, 16'h0100, 1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    task automatic test_random_moves(int n_moves);
        logic [31:0] start;
        logic [31:0] span;
        logic [30:0] speed;
        logic [30:0] accel;
        logic [15:0] tstep;
        repeat (n_moves) begin
            start = $urandom;
            span = $urandom >> $urandom_range(0, 20);
            speed = span[30:0] >> $urandom_range(0, 5);
            if ($urandom_range(0, 9) == 0) speed = 31'($urandom);
            if (speed == 0) speed = 1;
            accel = speed >> $urandom_range(0, 4);
            if ($urandom_range(0, 9) == 0) accel = 31'($urandom);
            if (accel == 0) accel = 1;
            tstep = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(16384, 65535))
                                                : 16'($urandom_range(1, 65535));
            set_move(start, $urandom_range(0, 1) ? start + span : start - span, speed, accel,
                     tstep, $urandom_range(0, 3) == 0);
            send_tick(1'b1);
            repeat (39) send_tick($urandom_range(0, 29) == 0);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_restart = 1'b0;
        cfg_start = 0;
        cfg_target = 0;
        cfg_speed = 31'd65536;
        cfg_accel = 31'd65536;
        cfg_tstep = 16'd655;
        cfg_tri = 1'b0;
        elapsed = '0;
        done_flag = 1'b0;
        n_errors = 0;
        n_ticks = 0;
        n_done_seen = 0;
        n_checked = 0;
        calm = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_short_moves();
        test_extremes();
        test_sticky_done();
        test_random_moves(34);
        calm = 1'b1;
        test_random_moves(4);
        wait_idle();
        repeat (200) @(posedge aclk);
        $display("Ran %0d ticks over many move settings; %0d results checked, %0d with done.",
                 n_ticks, n_checked, n_done_seen);
        if (n_errors == 0 && setpoint_queue.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/tpg_pkg.sv
src/tpg_divider.sv
src/trapezoidal_profile_generator.sv
tb/tb.sv
